[src/nearest_box_search_assert.svh]
// Assertion macros used by the nearest box search back end.
`ifndef NEAREST_BOX_SEARCH_ASSERT_SVH
`define NEAREST_BOX_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define NBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/nbs_pkg.sv]
package nbs_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SIZE_BITS      = 12;
   localparam int DIFF_BITS      = COORD_BITS + 2;
   localparam int SQ_BITS        = 2 * DIFF_BITS;
   localparam int DIST_BITS      = SQ_BITS + 1;
   localparam int ROOT_BITS      = (DIST_BITS + 1) / 2;
   localparam int DSQ_BITS       = 29;
   localparam int DHALF_BITS     = 15;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_BEGIN = 2'd0;
   localparam logic [1:0] ACT_BOX   = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   typedef enum logic [1:0] {
      OP_BEGIN,
      OP_BOX,
      OP_END
   } op_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [COORD_BITS-1:0] box_x;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_w;
      logic [COORD_BITS-1:0] box_h;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [COORD_BITS-1:0] nearest_x;
      logic [COORD_BITS-1:0] nearest_y;
      logic [COORD_BITS-1:0] nearest_w;
      logic [COORD_BITS-1:0] nearest_h;
      logic [DSQ_BITS-1:0]   dist_sq_quarter;
      logic [DHALF_BITS-1:0] dist_half_pixels;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [COORD_BITS-1:0] box_x;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_w;
      logic [COORD_BITS-1:0] box_h;
      logic [DIFF_BITS-1:0]  dx;
      logic [DIFF_BITS-1:0]  dy;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic start;
      logic take;
   } sqrt_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

[src/nearest_box_search.sv]
// Nearest box search. A begin transaction (action 0) loads the query point
// and clears the search, each candidate transaction (action 1) offers one box,
// and an end transaction (action 2) returns one result: a found flag, the box
// whose centre lies closest to the point, the exact squared centre distance in
// quarter-pixel units and its floor square root in half-pixel units. Boxes
// narrower or shorter than the min_size register are ignored, a tie keeps the
// earlier box, and action 3 is dropped. Begin and candidate transactions are
// taken one per clock cycle. An end transaction passes through the square
// root unit, which produces one result bit per cycle; while it works,
// candidates of the next search keep flowing, and only a second end waits
// until the first result has moved to the output register. The request side
// stalls only when the four-entry queue between the input stage and the
// search stage is full.
module nearest_box_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nbs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output nbs_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nbs_pkg::SIZE_BITS-1:0]  csr_data
);

   // Minimum size register; the user must write it only while the block is idle
   // (not enforced here), so the input stage may read it without any hand-off.
   logic [nbs_pkg::SIZE_BITS-1:0] min_size_ff, min_size_in;

   logic                    q_push, q_pop;
   nbs_pkg::entry_type      q_push_data, q_pop_data;
   nbs_pkg::queue_stat_type q_stat;

   assign csr_ready   = 1'b1;
   assign min_size_in = (csr_valid && csr_ready) ? csr_data : min_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= '0;
      end else begin
         min_size_ff <= min_size_in;
      end
   end

   // The input stage holds the query point, filters small boxes and computes
   // the doubled-coordinate centre offsets of each box.
   nbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .min_size  (min_size_ff),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (q_push_data)
   );

   // The queue lets the input stage keep taking transactions while the
   // search stage waits on the square root unit or on a stalled result.
   nbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   // The search stage squares the offsets, keeps the best box and finishes
   // each end transaction through the square root unit and output register.
   nbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_pop_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/nbs_queue.sv]
module nbs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nbs_pkg::entry_type     push_data,
   input  logic                   pop,
   output nbs_pkg::entry_type     pop_data,
   output nbs_pkg::queue_stat_type stat
);

   nbs_pkg::entry_type                   slot_ff [nbs_pkg::QUEUE_DEPTH];
   logic [nbs_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [nbs_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [nbs_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                                 do_push, do_pop;

   assign stat.full  = (count_ff == nbs_pkg::QUEUE_CNT_BITS'(nbs_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == nbs_pkg::QUEUE_PTR_BITS'(nbs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == nbs_pkg::QUEUE_PTR_BITS'(nbs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/nbs_front.sv]
module nbs_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nbs_pkg::req_type               req_data,
   input  logic [nbs_pkg::SIZE_BITS-1:0]  min_size,
   input  nbs_pkg::queue_stat_type        q_stat,
   output logic                           push,
   output nbs_pkg::entry_type             push_data
);

   logic [nbs_pkg::COORD_BITS-1:0] query_x_ff, query_x_in;
   logic [nbs_pkg::COORD_BITS-1:0] query_y_ff, query_y_in;
   logic                           accept;
   logic                           too_small;
   logic [nbs_pkg::DIFF_BITS-1:0]  px2, py2, cx2, cy2;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Both sides are widened to a common width before the size test.
   assign too_small =
      ({{nbs_pkg::SIZE_BITS{1'b0}}, req_data.box_w} <
       {{nbs_pkg::COORD_BITS{1'b0}}, min_size}) ||
      ({{nbs_pkg::SIZE_BITS{1'b0}}, req_data.box_h} <
       {{nbs_pkg::COORD_BITS{1'b0}}, min_size});

   // Centres are kept in doubled coordinates so that they stay integral.
   assign px2 = nbs_pkg::DIFF_BITS'({query_x_ff, 1'b0});
   assign py2 = nbs_pkg::DIFF_BITS'({query_y_ff, 1'b0});
   assign cx2 = nbs_pkg::DIFF_BITS'({req_data.box_x, 1'b0}) +
                nbs_pkg::DIFF_BITS'(req_data.box_w);
   assign cy2 = nbs_pkg::DIFF_BITS'({req_data.box_y, 1'b0}) +
                nbs_pkg::DIFF_BITS'(req_data.box_h);

   always_comb begin
      push_data.op    = nbs_pkg::OP_BOX;
      push_data.box_x = req_data.box_x;
      push_data.box_y = req_data.box_y;
      push_data.box_w = req_data.box_w;
      push_data.box_h = req_data.box_h;
      push_data.dx    = (px2 >= cx2) ? px2 - cx2 : cx2 - px2;
      push_data.dy    = (py2 >= cy2) ? py2 - cy2 : cy2 - py2;
      push            = 1'b0;
      query_x_in      = query_x_ff;
      query_y_in      = query_y_ff;
      if (accept) begin
         case (req_data.action)
            nbs_pkg::ACT_BEGIN: begin
               push_data.op = nbs_pkg::OP_BEGIN;
               push         = 1'b1;
               query_x_in   = req_data.point_x;
               query_y_in   = req_data.point_y;
            end
            nbs_pkg::ACT_BOX: begin
               push = !too_small;
            end
            nbs_pkg::ACT_END: begin
               push_data.op = nbs_pkg::OP_END;
               push         = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else begin
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
      end
   end

endmodule

[src/nbs_sqrt.sv]
module nbs_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  nbs_pkg::sqrt_cmd_type          cmd,
   input  logic [nbs_pkg::DIST_BITS-1:0]  value,
   output nbs_pkg::sqrt_stat_type         stat,
   output logic [nbs_pkg::ROOT_BITS-1:0]  root
);

   localparam int W = nbs_pkg::DIST_BITS + 1;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_RUN,
      SQ_DONE
   } sqrt_state_type;

   sqrt_state_type state_ff;
   logic [W-1:0]   rem_ff;
   logic [W-1:0]   root_ff;
   logic [W-1:0]   bit_ff;
   logic [W-1:0]   trial;

   assign trial     = root_ff + bit_ff;
   assign stat.busy = (state_ff != SQ_IDLE);
   assign stat.done = (state_ff == SQ_DONE);
   assign root      = nbs_pkg::ROOT_BITS'(root_ff);

   // Restoring square root, one result bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         case (state_ff)
            SQ_IDLE: begin
               if (cmd.start) begin
                  state_ff <= SQ_RUN;
                  rem_ff   <= W'(value);
                  root_ff  <= '0;
                  bit_ff   <= W'(1) << (2 * (nbs_pkg::ROOT_BITS - 1));
               end
            end
            SQ_RUN: begin
               if (rem_ff >= trial) begin
                  rem_ff  <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if ((bit_ff >> 2) == '0) begin
                  state_ff <= SQ_DONE;
               end
            end
            SQ_DONE: begin
               if (cmd.take) begin
                  state_ff <= SQ_IDLE;
               end
            end
            default: begin
               state_ff <= SQ_IDLE;
            end
         endcase
      end
   end

endmodule

[src/nbs_back.sv]
`include "nearest_box_search_assert.svh"

module nbs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  nbs_pkg::queue_stat_type q_stat,
   input  nbs_pkg::entry_type      q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output nbs_pkg::rsp_type        rsp_data
);

   // Squaring stage.
   logic                            s1_valid_ff, s1_valid_in;
   nbs_pkg::op_type                 s1_op_ff;
   logic [nbs_pkg::COORD_BITS-1:0]  s1_x_ff, s1_y_ff, s1_w_ff, s1_h_ff;
   logic [nbs_pkg::SQ_BITS-1:0]     s1_sqx_ff, s1_sqy_ff;
   logic [nbs_pkg::SQ_BITS-1:0]     sqx, sqy;

   // Running best.
   logic                            best_valid_ff, best_valid_in;
   logic [nbs_pkg::COORD_BITS-1:0]  best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [nbs_pkg::COORD_BITS-1:0]  best_w_ff, best_w_in, best_h_ff, best_h_in;
   logic [nbs_pkg::DIST_BITS-1:0]   best_d_ff, best_d_in;

   // Result waiting for its square root.
   logic                            pend_found_ff;
   logic [nbs_pkg::COORD_BITS-1:0]  pend_x_ff, pend_y_ff, pend_w_ff, pend_h_ff;
   logic [nbs_pkg::DIST_BITS-1:0]   pend_d_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   nbs_pkg::rsp_type                rsp_data_ff;

   logic                            exec, exec_end, s1_load, rsp_free, rsp_load;
   logic [nbs_pkg::DIST_BITS-1:0]   d;
   nbs_pkg::sqrt_cmd_type           sq_cmd;
   nbs_pkg::sqrt_stat_type          sq_stat;
   logic [nbs_pkg::ROOT_BITS-1:0]   sq_root;

   assign sqx = q_data.dx * q_data.dx;
   assign sqy = q_data.dy * q_data.dy;
   assign d   = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};

   // An end waits here until the root unit has handed off the previous result.
   assign exec     = s1_valid_ff && !(s1_op_ff == nbs_pkg::OP_END && sq_stat.busy);
   assign exec_end = exec && (s1_op_ff == nbs_pkg::OP_END);
   assign s1_load  = !s1_valid_ff || exec;
   assign pop      = s1_load && !q_stat.empty;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = sq_stat.done && rsp_free;
   assign sq_cmd.start = exec_end;
   assign sq_cmd.take  = rsp_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   nbs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (sq_cmd),
      .value (best_d_ff),
      .stat  (sq_stat),
      .root  (sq_root)
   );

   always_comb begin
      s1_valid_in   = s1_load ? !q_stat.empty : s1_valid_ff;
      best_valid_in = best_valid_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_w_in     = best_w_ff;
      best_h_in     = best_h_ff;
      best_d_in     = best_d_ff;
      if (exec) begin
         case (s1_op_ff)
            nbs_pkg::OP_BOX: begin
               if (!best_valid_ff || d < best_d_ff) begin
                  best_valid_in = 1'b1;
                  best_x_in     = s1_x_ff;
                  best_y_in     = s1_y_ff;
                  best_w_in     = s1_w_ff;
                  best_h_in     = s1_h_ff;
                  best_d_in     = d;
               end
            end
            default: begin
               best_valid_in = 1'b0;
               best_x_in     = '0;
               best_y_in     = '0;
               best_w_in     = '0;
               best_h_in     = '0;
               best_d_in     = '0;
            end
         endcase
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_w_ff     <= '0;
         best_h_ff     <= '0;
         best_d_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         best_valid_ff <= best_valid_in;
         best_x_ff     <= best_x_in;
         best_y_ff     <= best_y_in;
         best_w_ff     <= best_w_in;
         best_h_ff     <= best_h_in;
         best_d_ff     <= best_d_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff  <= q_data.op;
         s1_x_ff   <= q_data.box_x;
         s1_y_ff   <= q_data.box_y;
         s1_w_ff   <= q_data.box_w;
         s1_h_ff   <= q_data.box_h;
         s1_sqx_ff <= sqx;
         s1_sqy_ff <= sqy;
      end
      if (exec_end) begin
         pend_found_ff <= best_valid_ff;
         pend_x_ff     <= best_x_ff;
         pend_y_ff     <= best_y_ff;
         pend_w_ff     <= best_w_ff;
         pend_h_ff     <= best_h_ff;
         pend_d_ff     <= best_d_ff;
      end
      if (rsp_load) begin
         rsp_data_ff.found            <= pend_found_ff;
         rsp_data_ff.nearest_x        <= pend_x_ff;
         rsp_data_ff.nearest_y        <= pend_y_ff;
         rsp_data_ff.nearest_w        <= pend_w_ff;
         rsp_data_ff.nearest_h        <= pend_h_ff;
         rsp_data_ff.dist_sq_quarter  <= nbs_pkg::DSQ_BITS'(pend_d_ff);
         rsp_data_ff.dist_half_pixels <= nbs_pkg::DHALF_BITS'(sq_root);
      end
   end

   `NBS_ASSERT_NEXT(a_end_starts_root, clock, reset, exec_end, sq_stat.busy,
                    "end transaction did not start the square root")
   `NBS_ASSERT_NEXT(a_root_reaches_output, clock, reset, rsp_load, rsp_valid_ff,
                    "finished square root was not loaded into the output register")
   `NBS_ASSERT_NOW(a_empty_best_is_zero, clock, reset, !best_valid_ff,
                   best_d_ff == '0, "distance held without a valid best box")

endmodule

[tb/sv/nearest_box_checker.sv]
// Watches the request, result and register channels of the nearest box search,
// keeps its own copy of the search state and compares every result transaction
// field by field with the oldest outstanding prediction.
module nearest_box_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  nbs_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  nbs_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [nbs_pkg::SIZE_BITS-1:0]  csr_data,
   output int                             fault_count,
   output int                             pending_results
);

   import nbs_pkg::*;

   logic [SIZE_BITS-1:0]  min_size_reg;
   logic [COORD_BITS-1:0] query_x;
   logic [COORD_BITS-1:0] query_y;
   logic                  lead_found;
   logic [COORD_BITS-1:0] lead_x;
   logic [COORD_BITS-1:0] lead_y;
   logic [COORD_BITS-1:0] lead_w;
   logic [COORD_BITS-1:0] lead_h;
   int                    lead_dist_sq;
   rsp_type               awaited_results[$];
   int                    result_number;

   initial begin
      fault_count     = 0;
      pending_results = 0;
      result_number   = 0;
   end

   task automatic report_mismatch(string what);
      fault_count++;
      if (fault_count <= 100) begin
         $display("nearest_box_checker @%0t: %s", $time, what);
      end
   endtask

   // Floor square root, built up one result bit at a time from the top.
   function automatic logic [DHALF_BITS-1:0] half_pixel_root(int value);
      logic [DHALF_BITS-1:0] root;
      logic [DHALF_BITS-1:0] trial;
      int                    i;
      root = '0;
      for (i = DHALF_BITS - 1; i >= 0; i--) begin
         trial = root | (DHALF_BITS'(1) << i);
         if (longint'(trial) * longint'(trial) <= longint'(value)) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic clear_lead();
      lead_found   = 1'b0;
      lead_x       = '0;
      lead_y       = '0;
      lead_w       = '0;
      lead_h       = '0;
      lead_dist_sq = 0;
   endtask

   task automatic absorb_request(req_type r);
      int      dx;
      int      dy;
      int      dist_sq;
      rsp_type outcome;
      case (r.action)
         ACT_BEGIN: begin
            query_x = r.point_x;
            query_y = r.point_y;
            clear_lead();
         end
         ACT_BOX: begin
            if (r.box_w >= min_size_reg && r.box_h >= min_size_reg) begin
               // Doubled coordinates keep the half-pixel box centre exact.
               dx = 2 * int'(query_x) - (2 * int'(r.box_x) + int'(r.box_w));
               dy = 2 * int'(query_y) - (2 * int'(r.box_y) + int'(r.box_h));
               dist_sq = dx * dx + dy * dy;
               if (!lead_found || dist_sq < lead_dist_sq) begin
                  lead_found   = 1'b1;
                  lead_x       = r.box_x;
                  lead_y       = r.box_y;
                  lead_w       = r.box_w;
                  lead_h       = r.box_h;
                  lead_dist_sq = dist_sq;
               end
            end
         end
         ACT_END: begin
            outcome.found            = lead_found;
            outcome.nearest_x        = lead_x;
            outcome.nearest_y        = lead_y;
            outcome.nearest_w        = lead_w;
            outcome.nearest_h        = lead_h;
            outcome.dist_sq_quarter  = DSQ_BITS'(lead_dist_sq);
            outcome.dist_half_pixels = half_pixel_root(lead_dist_sq);
            awaited_results.push_back(outcome);
            clear_lead();
         end
         default: begin
            // The spare action code leaves everything as it is.
         end
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   result_number, name, got, want));
      end
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with none outstanding",
                                   result_number));
      end else begin
         want = awaited_results.pop_front();
         check_field("found", 32'(got.found), 32'(want.found));
         check_field("nearest_x", 32'(got.nearest_x), 32'(want.nearest_x));
         check_field("nearest_y", 32'(got.nearest_y), 32'(want.nearest_y));
         check_field("nearest_w", 32'(got.nearest_w), 32'(want.nearest_w));
         check_field("nearest_h", 32'(got.nearest_h), 32'(want.nearest_h));
         check_field("dist_sq_quarter", 32'(got.dist_sq_quarter),
                     32'(want.dist_sq_quarter));
         check_field("dist_half_pixels", 32'(got.dist_half_pixels),
                     32'(want.dist_half_pixels));
      end
      result_number++;
   endtask

   // A result accepted at an edge can only stem from an end taken earlier,
   // so results are compared before the request of the same edge is absorbed.
   always @(posedge clock) begin
      if (reset) begin
         min_size_reg = '0;
         query_x      = '0;
         query_y      = '0;
         clear_lead();
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            absorb_request(req_data);
         end
         if (csr_valid && csr_ready) begin
            min_size_reg = csr_data;
         end
      end
      pending_results = awaited_results.size();
   end

endmodule

[tb/sv/tb.sv]
// Top of the nearest box search testbench. It drives request transactions in
// bursts with random gaps, stalls the result channel on a changing pattern of
// its own and writes the minimum size register between phases, while the
// checker beside the block predicts and compares every result transaction.
module tb;

   import nbs_pkg::*;

   // Spare action code that the block must drop.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // An end transaction passes through the square root unit and up to four
   // transactions wait in the internal queue, so this is ample time for the
   // block to settle once the last result has been seen.
   localparam int SETTLE_CYCLES = 40;
   localparam int RUN_LIMIT     = 4_000_000;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int REQ_BITS      = $bits(req_type);

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SIZE_BITS-1:0] csr_data  = '0;

   int fault_count;
   int pending_results;

   // Stimulus bookkeeping: the register value the generator aims at, the
   // query point the block currently searches around and the last box sent,
   // which is used to build boxes whose centre ties with it.
   int      min_size_now  = 0;
   int      query_x_now   = 0;
   int      query_y_now   = 0;
   req_type last_box      = '0;
   logic    have_last_box = 1'b0;
   int      burst_left    = 0;
   int      gap_max       = 0;
   int      sent_items    = 0;

   nearest_box_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   nearest_box_checker nbs_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fault_count     (fault_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or loses a result.
   initial begin
      #(RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // The result side stalls on a pattern that is picked anew at random times:
   // never, at random, in long runs, or only now and then.
   int stall_mode = 0;
   int stall_span = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 120);
      end
      stall_span--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= (stall_span % 8) < 6;
         default: rsp_stall <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic int clamp_coord(int v);
      if (v < 0) begin
         return 0;
      end
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      return v;
   endfunction

   // Every transaction starts out fully random, so the fields that its action
   // does not use still toggle and must be ignored by the block.
   function automatic req_type noise_item();
      req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom});
      return r;
   endfunction

   function automatic req_type begin_item(int x, int y);
      req_type r;
      r         = noise_item();
      r.action  = ACT_BEGIN;
      r.point_x = COORD_BITS'(x);
      r.point_y = COORD_BITS'(y);
      return r;
   endfunction

   function automatic req_type box_item(int x, int y, int w, int h);
      req_type r;
      r        = noise_item();
      r.action = ACT_BOX;
      r.box_x  = COORD_BITS'(x);
      r.box_y  = COORD_BITS'(y);
      r.box_w  = COORD_BITS'(w);
      r.box_h  = COORD_BITS'(h);
      return r;
   endfunction

   function automatic req_type end_item();
      req_type r;
      r        = noise_item();
      r.action = ACT_END;
      return r;
   endfunction

   function automatic req_type unused_item();
      req_type r;
      r        = noise_item();
      r.action = ACT_UNUSED;
      return r;
   endfunction

   // Sends one request transaction. The sender works in bursts: when a burst
   // runs out it drops valid for a random gap, if any, and then starts the next one.
   // Valid stays high from one transaction to the next inside a burst, and the
   // payload is held for as long as the block stalls.
   task automatic drive_item(req_type item);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      case (item.action)
         ACT_BEGIN: begin
            query_x_now = int'(item.point_x);
            query_y_now = int'(item.point_y);
         end
         ACT_BOX: begin
            last_box      = item;
            have_last_box = 1'b1;
         end
         default: begin
         end
      endcase
      if (item.action != ACT_UNUSED) begin
         sent_items++;
      end
   endtask

   // Holds the sender back until every predicted result has come back, then
   // lets the block settle. The checker updates its count at the rising edge,
   // so the count is read at falling edges only.
   task automatic drain();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (pending_results != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The register is only written while the block is idle.
   task automatic write_min_size(int value);
      drain();
      csr_valid = 1'b1;
      csr_data  = SIZE_BITS'(value);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      min_size_now = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Box sizes are spread around the current minimum: below it, right on it,
   // a little above it, anywhere above it, and the largest size.
   function automatic int pick_size();
      case ($urandom_range(0, 7))
         0:       return (min_size_now > 0) ? $urandom_range(0, min_size_now - 1) : 0;
         1:       return min_size_now;
         2:       return COORD_MAX;
         3, 4:    return clamp_coord(min_size_now + $urandom_range(0, 15));
         default: return $urandom_range(min_size_now, COORD_MAX);
      endcase
   endfunction

   // Builds a candidate box. Most boxes sit near the query point so that the
   // search has close contenders; some are anywhere; some keep the centre of
   // the previous box exactly while changing its edges, which makes a tie that
   // the block must resolve in favor of the earlier box.
   function automatic req_type candidate_box();
      int w;
      int h;
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 1 && have_last_box && last_box.box_x > 0
          && last_box.box_w <= COORD_MAX - 2) begin
         return box_item(int'(last_box.box_x) - 1, int'(last_box.box_y),
                         int'(last_box.box_w) + 2, int'(last_box.box_h));
      end
      if (pick == 2 && have_last_box && last_box.box_y > 0
          && last_box.box_h <= COORD_MAX - 2) begin
         return box_item(int'(last_box.box_x), int'(last_box.box_y) - 1,
                         int'(last_box.box_w), int'(last_box.box_h) + 2);
      end
      w = pick_size();
      h = pick_size();
      if (pick == 0) begin
         return box_item($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), w, h);
      end
      return box_item(clamp_coord(query_x_now - w / 2 + $urandom_range(0, 40) - 20),
                      clamp_coord(query_y_now - h / 2 + $urandom_range(0, 40) - 20), w, h);
   endfunction

   function automatic int pick_point();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   // One step of the random stimulus. Most steps are a complete search with
   // random content; the rest are stray transactions, spare action codes and
   // pauses in which the sender waits for all outstanding results.
   task automatic random_search();
      int pick;
      int box_count;
      int i;
      pick = $urandom_range(0, 39);
      case (pick)
         0: drive_item(unused_item());
         1: drive_item(box_item($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                pick_size(), pick_size()));
         2: drive_item(end_item());
         3: drain();
         default: begin
            // Now and then the begin is left out, so the search runs around
            // the point that the block kept from the previous query.
            if ($urandom_range(0, 7) != 0) begin
               drive_item(begin_item(pick_point(), pick_point()));
               have_last_box = 1'b0;
            end
            box_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                    : $urandom_range(0, 8);
            for (i = 0; i < box_count; i++) begin
               drive_item(candidate_box());
            end
            drive_item(end_item());
         end
      endcase
   endtask

   task automatic random_phase(int min_size, int count, int gaps);
      int target;
      write_min_size(min_size);
      gap_max = gaps;
      target  = sent_items + count;
      while (sent_items < target) begin
         random_search();
      end
   endtask

   initial begin
      gap_max = 3;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, minimum size still at its reset value of zero.
      // A box before any begin is searched around the origin.
      drive_item(box_item(10, 20, 4, 6));
      drive_item(end_item());
      // An end with nothing found returns all zeros.
      drive_item(end_item());
      // Extreme coordinates, a zero-sized box and the farthest possible box.
      drive_item(begin_item(COORD_MAX, COORD_MAX));
      drive_item(box_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      drive_item(box_item(0, 0, 0, 0));
      drive_item(end_item());
      drive_item(begin_item(0, 0));
      drive_item(box_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      drive_item(box_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      drive_item(end_item());
      // Two boxes centered exactly on the point: the first one must win, and
      // the spare action code in between must change nothing.
      drive_item(begin_item(100, 100));
      drive_item(box_item(90, 90, 20, 20));
      drive_item(box_item(95, 95, 10, 10));
      drive_item(unused_item());
      drive_item(end_item());
      // After an end the point is kept and a new search starts around it.
      drive_item(box_item(101, 99, 0, 0));
      drive_item(box_item(99, 101, 0, 0));
      drive_item(end_item());

      // Largest minimum size: only a full-size box qualifies.
      write_min_size(COORD_MAX);
      drive_item(begin_item(2048, 0));
      drive_item(box_item(0, 0, COORD_MAX - 1, COORD_MAX));
      drive_item(box_item(0, 0, COORD_MAX, COORD_MAX - 1));
      drive_item(box_item(7, 9, COORD_MAX, COORD_MAX));
      drive_item(end_item());

      // Random phases over several register settings and sender behaviors,
      // two of them with no gaps at all on the request side.
      random_phase(0, 300, 4);
      random_phase(COORD_MAX, 200, 6);
      random_phase(1, 250, 0);
      random_phase(2048, 250, 3);
      random_phase($urandom_range(2, 64), 300, 5);
      random_phase($urandom_range(0, COORD_MAX), 200, 2);
      random_phase(0, 200, 0);

      drain();
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
